// File: rtl/core/tsr_pkg.sv
// Package for the thermocouple SPI reader: shared widths, codes and the
// result word type passed from the sequencer to the output stage.
// No dependencies.
package tsr_pkg;

    // Configuration register width and register indexes
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS   = 2'd2;

    localparam logic [CFG_W-1:0] SETUP_TICKS_RST = 20'd1000;
    localparam logic [CFG_W-1:0] HIGH_TICKS_RST  = 20'd1000;
    localparam logic [CFG_W-1:0] LOW_TICKS_RST   = 20'd4000;

    // Frame layout
    localparam int FRAME_BITS = 16;
    localparam int BIT_CNT_W = 5;
    localparam int TEMP_W = 12;
    localparam int STATUS_W = 2;
    localparam int OPEN_BIT = 2;
    localparam int SIGN_BIT = 15;
    localparam int TEMP_LSB = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OPEN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIGN  = 2'd2;

    // Stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    // One result word
    typedef struct packed {
        logic [FRAME_BITS-1:0] raw_word;
        logic [TEMP_W-1:0]     temperature_quarters;
        logic [STATUS_W-1:0]   status;
        logic                  done_res;
        logic                  busy_res;
        logic                  select_n;
        logic                  sclk;
    } tsr_result_t;

endpackage

// File: rtl/core/tsr_cfg_regs.sv
// Configuration register file for the thermocouple SPI reader.
// Depends on tsr_pkg.
module tsr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsr_pkg::CFG_W-1:0]      cfg_data,
    output logic [tsr_pkg::CFG_W-1:0]      setup_ticks,
    output logic [tsr_pkg::CFG_W-1:0]      high_ticks,
    output logic [tsr_pkg::CFG_W-1:0]      low_ticks
);

    logic [tsr_pkg::CFG_W-1:0] setup_ticks_reg;
    logic [tsr_pkg::CFG_W-1:0] high_ticks_reg;
    logic [tsr_pkg::CFG_W-1:0] low_ticks_reg;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_ticks_reg <= tsr_pkg::SETUP_TICKS_RST;
            high_ticks_reg  <= tsr_pkg::HIGH_TICKS_RST;
            low_ticks_reg   <= tsr_pkg::LOW_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tsr_pkg::REG_SETUP_TICKS: setup_ticks_reg <= cfg_data;
                tsr_pkg::REG_HIGH_TICKS:  high_ticks_reg  <= cfg_data;
                tsr_pkg::REG_LOW_TICKS:   low_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign setup_ticks = setup_ticks_reg;
    assign high_ticks  = high_ticks_reg;
    assign low_ticks   = low_ticks_reg;

endmodule

// File: rtl/core/tsr_sequencer.sv
// Frame sequencer: phase, tick timer, bit counter, shift register and decode.
// Depends on tsr_pkg.
module tsr_sequencer #(
    parameter int TIMER_BITS = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       start_req,
    input  logic                       data_in,
    input  logic [tsr_pkg::CFG_W-1:0]  setup_ticks,
    input  logic [tsr_pkg::CFG_W-1:0]  high_ticks,
    input  logic [tsr_pkg::CFG_W-1:0]  low_ticks,
    output tsr_pkg::tsr_result_t       res
);

    localparam int SW = (TIMER_BITS > tsr_pkg::CFG_W) ? TIMER_BITS : tsr_pkg::CFG_W;
    localparam int CW = SW + 1;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PREP_A = 3'd1;
    localparam logic [2:0] PH_PREP_B = 3'd2;
    localparam logic [2:0] PH_SELECT = 3'd3;
    localparam logic [2:0] PH_HIGH   = 3'd4;
    localparam logic [2:0] PH_LOW    = 3'd5;
    localparam logic [2:0] PH_FINISH = 3'd6;

    logic [2:0]                          phase_reg, phase_next;
    logic [TIMER_BITS-1:0]               tick_reg, tick_next;
    logic [tsr_pkg::BIT_CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [tsr_pkg::FRAME_BITS-1:0]      shift_reg, shift_next;
    logic [tsr_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [tsr_pkg::TEMP_W-1:0]          temp_reg, temp_next;

    logic [tsr_pkg::CFG_W-1:0]           dur;
    logic [SW-1:0]                       dur_ext, lim, span;
    logic [CW-1:0]                       cnt_inc;
    logic                                elapsed;
    logic [tsr_pkg::BIT_CNT_W-1:0]       bit_inc;

    // Duration of the current phase, saturated to the timer and at least one
    always_comb begin
        case (phase_reg)
            PH_HIGH: dur = high_ticks;
            PH_LOW:  dur = low_ticks;
            default: dur = setup_ticks;
        endcase
        dur_ext = SW'(dur);
        lim     = SW'({TIMER_BITS{1'b1}});
        span    = (dur_ext > lim) ? lim : dur_ext;
        if (span == '0) begin
            span = SW'(1);
        end
        cnt_inc = CW'(tick_reg) + CW'(1);
        elapsed = (cnt_inc >= CW'(span));
    end

    assign bit_inc = bit_cnt_reg + tsr_pkg::BIT_CNT_W'(1);

    // Next state for one tick
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        status_next  = status_reg;
        temp_next    = temp_reg;
        case (phase_reg)
            PH_PREP_A, PH_PREP_B, PH_SELECT: begin
                tick_next = elapsed ? '0 : TIMER_BITS'(cnt_inc);
                if (elapsed) begin
                    phase_next = (phase_reg == PH_PREP_A) ? PH_PREP_B :
                                 (phase_reg == PH_PREP_B) ? PH_SELECT : PH_HIGH;
                end
            end
            PH_HIGH: begin
                tick_next = elapsed ? '0 : TIMER_BITS'(cnt_inc);
                if (elapsed) begin
                    shift_next = {shift_reg[tsr_pkg::FRAME_BITS-2:0], data_in};
                    phase_next = PH_LOW;
                end
            end
            PH_LOW: begin
                tick_next = elapsed ? '0 : TIMER_BITS'(cnt_inc);
                if (elapsed) begin
                    if (bit_inc >= tsr_pkg::BIT_CNT_W'(tsr_pkg::FRAME_BITS)) begin
                        bit_cnt_next = '0;
                        phase_next   = PH_FINISH;
                        // Decode: open thermocouple wins over sign
                        if (shift_reg[tsr_pkg::OPEN_BIT]) begin
                            status_next = tsr_pkg::STATUS_OPEN;
                            temp_next   = '0;
                        end else if (shift_reg[tsr_pkg::SIGN_BIT]) begin
                            status_next = tsr_pkg::STATUS_SIGN;
                            temp_next   = '0;
                        end else begin
                            status_next = tsr_pkg::STATUS_VALID;
                            temp_next   = shift_reg[tsr_pkg::TEMP_LSB +: tsr_pkg::TEMP_W];
                        end
                    end else begin
                        bit_cnt_next = bit_inc;
                        phase_next   = PH_HIGH;
                    end
                end
            end
            default: begin
                // idle or finish tick
                tick_next    = '0;
                bit_cnt_next = '0;
                phase_next   = start_req ? PH_PREP_A : PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            status_reg  <= tsr_pkg::STATUS_VALID;
            temp_reg    <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            status_reg  <= status_next;
            temp_reg    <= temp_next;
        end
    end

    // Levels of the phase in force at the start of the tick
    always_comb begin
        res.sclk                 = (phase_reg == PH_HIGH);
        res.select_n             = !((phase_reg == PH_SELECT) || (phase_reg == PH_HIGH) ||
                                     (phase_reg == PH_LOW));
        res.busy_res             = (phase_reg >= PH_PREP_A) && (phase_reg <= PH_LOW);
        res.done_res             = (phase_reg == PH_FINISH);
        res.status               = status_reg;
        res.temperature_quarters = temp_reg;
        res.raw_word             = shift_reg;
    end

endmodule

// File: rtl/core/tsr_out_stage.sv
// Output register for result words, with the stream handshake.
// Depends on tsr_pkg.
module tsr_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  tsr_pkg::tsr_result_t  res,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output tsr_pkg::tsr_result_t  word
);

    logic                 valid_reg;
    tsr_pkg::tsr_result_t word_reg;

    // Valid flag: set on load, cleared when taken with nothing new
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign word     = word_reg;

endmodule

// File: rtl/core/thermocouple_spi_reader_top.sv
// A result word is registered and appears in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle while the result side takes words; the
// single output register is refilled in the cycle it is drained.
// Reset (aresetn low, synchronous): idle phase, counters, shift word and held
// result cleared, registers back to 1000/1000/4000, no result word pending.
// Depends on tsr_pkg, tsr_cfg_regs, tsr_sequencer, tsr_out_stage.
module thermocouple_spi_reader_top #(
    parameter int TIMER_BITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Tick words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsr_pkg::S_DATA_W-1:0]   s_tdata,  // [0] start_req, [1] data_in
    // Result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] sclk, [1] select_n, [2] busy_res, [3] done_res, [5:4] status,
    // [17:6] temperature_quarters, [33:18] raw_word, rest zero
    output logic [tsr_pkg::M_DATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsr_pkg::CFG_W-1:0]      cfg_data
);

    logic [tsr_pkg::CFG_W-1:0] setup_ticks, high_ticks, low_ticks;
    logic                      step;
    tsr_pkg::tsr_result_t      res, word;

    // Accept while the output register is empty or being drained
    assign s_tready = !m_tvalid || m_tready;
    assign step     = s_tvalid && s_tready;

    tsr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .setup_ticks (setup_ticks),
        .high_ticks  (high_ticks),
        .low_ticks   (low_ticks)
    );

    tsr_sequencer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .start_req   (s_tdata[0]),
        .data_in     (s_tdata[1]),
        .setup_ticks (setup_ticks),
        .high_ticks  (high_ticks),
        .low_ticks   (low_ticks),
        .res         (res)
    );

    tsr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .word     (word)
    );

    assign m_tdata = tsr_pkg::M_DATA_W'(word);

endmodule

// File: rtl/core/tsr_checker.sv
// Port-level checks for the thermocouple SPI reader, bound to the top level.
// Depends on tsr_pkg and thermocouple_spi_reader_top.
module tsr_bind_checks (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tsr_pkg::M_DATA_W-1:0]  m_tdata
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Clock high only inside a selected, busy frame
    a_sclk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[1] && m_tdata[2])
        else $error("sclk high outside selected frame");

    // Finish word is never busy and has select released
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2] && m_tdata[1])
        else $error("done while busy or selected");

    // Temperature is zero unless the status is valid
    a_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:4] != tsr_pkg::STATUS_VALID) |-> (m_tdata[17:6] == '0))
        else $error("temperature set with fault status");

    // Input is taken whenever the output side can take a word
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

endmodule

bind thermocouple_spi_reader_top tsr_bind_checks u_tsr_bind_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tsr_checker.sv
// Checker for the thermocouple SPI reader: watches the tick, result and
// configuration channels, predicts every result word and compares it.
// Depends on tsr_pkg only.
module tsr_checker
    import tsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] start_req, [1] data_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] sclk, [1] select_n, [2] busy_res, [3] done_res, [5:4] status,
    // [17:6] temperature_quarters, [33:18] raw_word, rest zero
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    pending,
    output int                    errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W = $bits(tsr_result_t);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PREP_A,
        SEQ_PREP_B,
        SEQ_SELECT,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_FINISH
    } seq_phase_e;

    // Own copy of the registers and the sequencer state
    logic [CFG_W-1:0]      setup_reg;
    logic [CFG_W-1:0]      high_reg;
    logic [CFG_W-1:0]      low_reg;
    seq_phase_e            phase;
    logic [CFG_W-1:0]      tick_cnt;
    logic [BIT_CNT_W-1:0]  bits_done;
    logic [FRAME_BITS-1:0] shift_word;
    logic [STATUS_W-1:0]   held_status;
    logic [TEMP_W-1:0]     held_temp;

    // Expected result words, oldest first
    tsr_result_t result_q[$];

    initial errors = 0;

    // A zero duration lasts one tick; a 20-bit register never exceeds the timer
    function automatic logic [CFG_W:0] span_of(logic [CFG_W-1:0] r);
        return (r == '0) ? (CFG_W+1)'(1) : {1'b0, r};
    endfunction

    // Counts one tick of the current phase, true when the phase is over
    function automatic bit phase_elapsed(logic [CFG_W-1:0] r);
        logic [CFG_W:0] nxt;
        nxt = {1'b0, tick_cnt} + (CFG_W+1)'(1);
        if (nxt >= span_of(r)) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = nxt[CFG_W-1:0];
        return 1'b0;
    endfunction

    // Open thermocouple wins over the sign flag
    function automatic void latch_reading();
        if (shift_word[OPEN_BIT]) begin
            held_status = STATUS_OPEN;
            held_temp = '0;
        end else if (shift_word[SIGN_BIT]) begin
            held_status = STATUS_SIGN;
            held_temp = '0;
        end else begin
            held_status = STATUS_VALID;
            held_temp = shift_word[TEMP_LSB +: TEMP_W];
        end
    endfunction

    // Levels come from the phase in force at the start of the tick
    function automatic tsr_result_t step_tick(logic st, logic din);
        tsr_result_t res;
        res = '0;
        res.sclk = (phase == SEQ_HIGH);
        res.select_n = !(phase inside {SEQ_SELECT, SEQ_HIGH, SEQ_LOW});
        res.busy_res = (phase inside {SEQ_PREP_A, SEQ_PREP_B, SEQ_SELECT,
                                      SEQ_HIGH, SEQ_LOW});
        res.done_res = (phase == SEQ_FINISH);
        res.status = held_status;
        res.temperature_quarters = held_temp;
        res.raw_word = shift_word;

        case (phase)
            SEQ_PREP_A: begin
                if (phase_elapsed(setup_reg)) phase = SEQ_PREP_B;
            end
            SEQ_PREP_B: begin
                if (phase_elapsed(setup_reg)) phase = SEQ_SELECT;
            end
            SEQ_SELECT: begin
                if (phase_elapsed(setup_reg)) phase = SEQ_HIGH;
            end
            SEQ_HIGH: begin
                if (phase_elapsed(high_reg)) begin
                    shift_word = {shift_word[FRAME_BITS-2:0], din};
                    phase = SEQ_LOW;
                end
            end
            SEQ_LOW: begin
                if (phase_elapsed(low_reg)) begin
                    bits_done = bits_done + BIT_CNT_W'(1);
                    if (bits_done >= BIT_CNT_W'(FRAME_BITS)) begin
                        bits_done = '0;
                        latch_reading();
                        phase = SEQ_FINISH;
                    end else begin
                        phase = SEQ_HIGH;
                    end
                end
            end
            default: begin
                // idle or finish tick: a start is taken here
                tick_cnt = '0;
                bits_done = '0;
                phase = st ? SEQ_PREP_A : SEQ_IDLE;
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
        end
    endfunction

    // Predict on each tick word, compare on each result word
    always @(posedge aclk) begin
        tsr_result_t want;
        tsr_result_t got;
        if (!aresetn) begin
            setup_reg = SETUP_TICKS_RST;
            high_reg = HIGH_TICKS_RST;
            low_reg = LOW_TICKS_RST;
            phase = SEQ_IDLE;
            tick_cnt = '0;
            bits_done = '0;
            shift_word = '0;
            held_status = STATUS_VALID;
            held_temp = '0;
            result_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SETUP_TICKS: setup_reg = cfg_data;
                    REG_HIGH_TICKS:  high_reg = cfg_data;
                    REG_LOW_TICKS:   low_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_q.push_back(step_tick(s_tdata[0], s_tdata[1]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_W-1:0];
                if (result_q.size() == 0) begin
                    errors++;
                    $error("result word with no tick word pending");
                end else begin
                    want = result_q.pop_front();
                    check_field("sclk", 32'(want.sclk), 32'(got.sclk));
                    check_field("select_n", 32'(want.select_n), 32'(got.select_n));
                    check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("temperature_quarters",
                                32'(want.temperature_quarters),
                                32'(got.temperature_quarters));
                    check_field("raw_word", 32'(want.raw_word), 32'(got.raw_word));
                    check_field("padding", '0, 32'(m_tdata[M_DATA_W-1:RES_W]));
                end
            end
        end
        pending <= result_q.size();
    end

endmodule

// File: test/tb_top.sv
// Top of the thermocouple SPI reader testbench: clock, reset, tick and
// configuration stimulus, receiver back-pressure and the final verdict.
// Depends on tsr_pkg, thermocouple_spi_reader_top and tsr_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsr_pkg::*;

    // Index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CFG_W-1:0] TICKS_MAX = '1;
    localparam int PHASE_TICKS = 130;
    localparam int PHASE_FRAMES = 2;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;    // [0] start_req, [1] data_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] sclk, [1] select_n, [2] busy_res, [3] done_res, [5:4] status,
    // [17:6] temperature_quarters, [33:18] raw_word, rest zero
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int pending;
    int errors;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Tick counts in force, used to keep frames aligned with the sequencer
    int unsigned setup_span = 1;
    int unsigned high_span = 1;
    int unsigned low_span = 1;
    int ticks_fed;
    int frames_sent;

    thermocouple_spi_reader_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tsr_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One tick word, with random sender gaps in front of it
    task automatic push_tick(input logic st, input logic din);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W-2){1'b0}}, din, st};
        do @(posedge aclk); while (!s_tready);
        ticks_fed++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        int unsigned eff;
        eff = (val == '0) ? 1 : val;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SETUP_TICKS: setup_span = eff;
            REG_HIGH_TICKS:  high_span = eff;
            REG_LOW_TICKS:   low_span = eff;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stop sending and let every expected result word come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Enough quiet ticks for any frame in flight to run out
    task automatic flush_frame();
        repeat (3 * setup_span + FRAME_BITS * (high_span + low_span) + 2)
            push_tick(1'b0, 1'($urandom_range(1)));
    endtask

    // Well-formed frame from idle or the finish tick: data held over each bit,
    // stray starts while busy. Chained frames start on the finish tick.
    task automatic send_frame(input logic [FRAME_BITS-1:0] word, input bit chain);
        push_tick(1'b1, 1'($urandom_range(1)));
        repeat (3 * setup_span)
            push_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
        for (int k = FRAME_BITS - 1; k >= 0; k--) begin
            repeat (high_span + low_span) push_tick($urandom_range(3) == 0, word[k]);
        end
        if (!chain) begin
            repeat ($urandom_range(1, 3)) push_tick(1'b0, 1'($urandom_range(1)));
        end
        frames_sent++;
    endtask

    initial begin
        logic [FRAME_BITS-1:0] word;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: starts while busy, out-of-range index, extreme and zero
        // durations, and registers changed in the middle of a phase
        write_reg(REG_SETUP_TICKS, TICKS_MAX);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b1, 1'b1);
        wait_drained();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        write_reg(REG_SETUP_TICKS, '0);
        write_reg(REG_HIGH_TICKS, TICKS_MAX);
        repeat (5) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        wait_drained();
        write_reg(REG_HIGH_TICKS, '0);
        write_reg(REG_LOW_TICKS, TICKS_MAX);
        repeat (3) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        wait_drained();
        write_reg(REG_LOW_TICKS, '0);
        flush_frame();

        // Random: mostly whole frames with random or corner words, some noise
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_reg(REG_SETUP_TICKS, CFG_W'($urandom_range(0, 2)));
            write_reg(REG_HIGH_TICKS, CFG_W'($urandom_range(0, 2)));
            write_reg(REG_LOW_TICKS, CFG_W'($urandom_range(0, 2)));
            if ($urandom_range(1)) write_reg(REG_UNUSED, CFG_W'($urandom));
            ticks_fed = 0;
            frames_sent = 0;
            while (ticks_fed < PHASE_TICKS || frames_sent < PHASE_FRAMES) begin
                if ($urandom_range(99) < 80) begin
                    case ($urandom_range(0, 11))
                        0: word = 16'h7FF8;        // largest temperature
                        1: word = 16'h0004;        // open thermocouple
                        2: word = 16'h8000;        // sign flag alone
                        3: word = 16'h8004;        // open and sign together
                        4: word = 16'h0000;
                        5: word = 16'hFFFF;
                        default: word = FRAME_BITS'($urandom);
                    endcase
                    send_frame(word, 1'($urandom_range(1)));
                end else begin
                    repeat ($urandom_range(1, 20))
                        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                    flush_frame();
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
